FILE: src/ccde_pkg.sv
`timescale 1ns / 1ps
package ccde_pkg;

  // datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_LATCH, OP_DIV_MOD, OP_DIV_K, OP_SET_K, OP_MUL_A, OP_SET_A,
    OP_MUL_U, OP_SET_U, OP_MUL_UT, OP_DIV_T, OP_SET_T, OP_MUL_S, OP_SET_S, OP_SET_CS,
    OP_RD, OP_MUL_DX, OP_SET_DX, OP_MUL_DY, OP_SET_DY, OP_MUL_MX, OP_SET_MX, OP_MUL_MY,
    OP_SET_M, OP_MUL_W, OP_SET_W, OP_MUL_N, OP_SET_N, OP_DIV_Q, OP_ADD_T, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       sel;   // 0: sine of r, 1: sine of quarter minus r
    logic [2:0] m;     // taylor term
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic den_zero;
    logic out_busy;
    logic n_zero;
    logic last_term;
  } dp_stat_t;

  // exact division by a taylor divisor: shift out the power of two,
  // multiply by the rounded-up reciprocal of the odd part, shift down
  typedef struct packed {
    logic [1:0]  pre;
    logic [31:0] mul;
    logic [5:0]  post;
  } taylor_rcp_t;

  // register addresses (word index)
  localparam logic REG_CLUSTERS = 1'b0;
  localparam logic REG_PERIOD   = 1'b1;

  localparam logic [4:0]  CLUSTERS_RST = 5'd1;
  localparam logic [31:0] PERIOD_RST   = 32'd86400;

  localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
  localparam logic [33:0] INV_2PI_Q32 = 34'd683565276;
  localparam logic [63:0] ONE_Q30     = 64'h0000_0000_4000_0000;
  localparam logic [62:0] ONE_Q58     = 63'h0400_0000_0000_0000;
  localparam logic [63:0] TERM_CAP    = 64'h0000_0100_0000_0000;

  // reciprocal of the taylor divisor 2m*(2m+1), exact for dividends below 2^32
  function automatic taylor_rcp_t taylor_rcp(input logic [2:0] m);
    taylor_rcp_t c;
    case (m)
      3'd1:    c = '{pre: 2'd1, mul: 32'd2863311531, post: 6'd33};  // 2 * 3
      3'd2:    c = '{pre: 2'd2, mul: 32'd3435973837, post: 6'd34};  // 4 * 5
      3'd3:    c = '{pre: 2'd1, mul: 32'd3272356036, post: 6'd36};  // 2 * 21
      3'd4:    c = '{pre: 2'd3, mul: 32'd3817748708, post: 6'd35};  // 8 * 9
      3'd5:    c = '{pre: 2'd1, mul: 32'd2498890064, post: 6'd37};  // 2 * 55
      3'd6:    c = '{pre: 2'd2, mul: 32'd3524075731, post: 6'd37};  // 4 * 39
      3'd7:    c = '{pre: 2'd1, mul: 32'd2617884829, post: 6'd38};  // 2 * 105
      default: c = '{pre: 2'd1, mul: 32'd2863311531, post: 6'd33};
    endcase
    return c;
  endfunction

endpackage

FILE: src/ccde_div.sv
`timescale 1ns / 1ps
module ccde_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quotient_o,
  output logic [63:0] remainder_o
);

  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [64:0] rem_sh;
  logic        ge;

  // one restoring step per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[63]};
    ge     = rem_sh >= {1'b0, dvs_q};
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = 7'd64;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      rem_d = ge ? 64'(rem_sh - {1'b0, dvs_q}) : rem_sh[63:0];
      quo_d = {quo_q[62:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = cnt_q != 7'd0;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

FILE: src/ccde_dp.sv
`timescale 1ns / 1ps
module ccde_dp import ccde_pkg::*; #(
  parameter int MAX_CLUSTERS = 16,
  parameter int PHASE_BITS   = 12,
  parameter int AW           = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dp_cmd_t       cmd_i,
  input  logic [AW-1:0] idx_i,
  output dp_stat_t      stat_o,
  input  logic [4:0]    clusters_i,
  input  logic [31:0]   period_i,
  input  logic [3:0]    entry_index_i,
  input  logic [31:0]   centre_x_i,
  input  logic [31:0]   centre_y_i,
  input  logic [31:0]   cluster_weight_in_i,
  input  logic [31:0]   query_time_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   density_o,
  output logic          saturated_o
);

  localparam int PB = PHASE_BITS;
  localparam int NW = $clog2(MAX_CLUSTERS + 1);
  localparam int SW = 42 + $clog2(MAX_CLUSTERS + 1);
  localparam logic [PB-2:0] QTR  = (PB-1)'(1) << (PB - 2);
  localparam logic [SW-1:0] SMAX = SW'(64'h7fff_ffff);
  localparam logic [SW-1:0] SMIN = ~SMAX;

  // cluster tables
  logic [31:0] cx_mem [MAX_CLUSTERS];
  logic [31:0] cy_mem [MAX_CLUSTERS];
  logic [31:0] cw_mem [MAX_CLUSTERS];

  logic [31:0]   time_q, x_q, y_q, w_q, cs_q, sn_q;
  logic [PB-1:0] k_q;
  logic [30:0]   a_q, t_q, sa_q, ca_q;
  logic [31:0]   u_q;
  logic [67:0]   p_q;
  logic [61:0]   acc_q;
  logic [50:0]   den_q;
  logic [32:0]   om_q;
  logic          omneg_q;
  logic [33:0]   nw_q;
  logic [63:0]   num_q;
  logic [SW-1:0] sum_q;
  logic          sat_q;
  logic          out_valid_q;
  logic [31:0]   out_data_q;
  logic          out_sat_q;

  logic          div_start, div_busy;
  logic [63:0]   dvd, dvs, div_quo, div_rem;
  logic [33:0]   ma, mb, dx, dy, ax, ay, ux, uy, uw;
  logic [PB-3:0] r;
  logic [1:0]    quad;
  logic [PB-2:0] j;
  logic [62:0]   sq_sum, om_diff;
  logic          m2_big;
  logic [63:0]   s64;
  logic [NW-1:0] n_terms;
  logic          neg, term_neg, term_big;
  logic [40:0]   term_mag;
  logic [SW-1:0] term;
  taylor_rcp_t   rcp;
  logic [31:0]   t_quo;

  function automatic logic [33:0] abs34(input logic [33:0] v);
    return v[33] ? 34'(-v) : v;
  endfunction

  assign r    = k_q[PB-3:0];
  assign quad = k_q[PB-1:PB-2];
  assign j    = cmd_i.sel ? QTR - {1'b0, r} : {1'b0, r};

  // taylor divisor as shift, reciprocal multiply and shift
  assign rcp   = taylor_rcp(cmd_i.m);
  assign t_quo = 32'(p_q >> rcp.post);

  // differences and magnitudes for the current entry
  assign dx = {{2{cs_q[31]}}, cs_q} - {{2{x_q[31]}}, x_q};
  assign dy = {{2{sn_q[31]}}, sn_q} - {{2{y_q[31]}}, y_q};
  assign ax = abs34(dx);
  assign ay = abs34(dy);
  assign ux = abs34({{2{x_q[31]}}, x_q});
  assign uy = abs34({{2{y_q[31]}}, y_q});
  assign uw = abs34({{2{w_q[31]}}, w_q});

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_MUL_A:  begin ma = 34'(j);   mb = TWO_PI_Q30;  end
      OP_MUL_U:  begin ma = 34'(a_q); mb = 34'(a_q);    end
      OP_MUL_UT: begin ma = 34'(u_q); mb = 34'(t_q);    end
      OP_DIV_T:  begin ma = p_q[63:30] >> rcp.pre; mb = 34'(rcp.mul); end
      OP_MUL_S:  begin ma = 34'(a_q); mb = 34'(t_q);    end
      OP_MUL_DX: begin ma = ax;       mb = ax;          end
      OP_MUL_DY: begin ma = ay;       mb = ay;          end
      OP_MUL_MX: begin ma = ux;       mb = ux;          end
      OP_MUL_MY: begin ma = uy;       mb = uy;          end
      OP_MUL_W:  begin ma = uw;       mb = 34'(om_q);   end
      OP_MUL_N:  begin ma = nw_q;     mb = INV_2PI_Q32; end
      default:   begin ma = '0;       mb = '0;          end
    endcase
  end

  // divider operand select
  always_comb begin
    div_start = 1'b1;
    dvd       = '0;
    dvs       = '0;
    case (cmd_i.op)
      OP_DIV_MOD: begin dvd = 64'(time_q); dvs = 64'(period_i); end
      OP_DIV_K:   begin dvd = 64'(div_rem[31:0]) << PB; dvs = 64'(period_i); end
      OP_DIV_Q:   begin dvd = num_q; dvs = 64'(den_q); end
      default:    begin div_start = 1'b0; end
    endcase
  end

  ccde_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (dvd),
    .divisor_i   (dvs),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // combinational helpers for the set steps
  assign sq_sum  = 63'(acc_q) + 63'(p_q >> 2);
  assign m2_big  = sq_sum > ONE_Q58;
  assign om_diff = m2_big ? sq_sum - ONE_Q58 : ONE_Q58 - sq_sum;
  assign s64     = 64'(p_q >> 30);
  assign neg     = w_q[31] ^ omneg_q;
  assign term_big = div_quo > TERM_CAP;
  assign term_mag = (den_q == '0 || term_big) ? TERM_CAP[40:0] : div_quo[40:0];
  assign term_neg = (den_q == '0) ? (neg && num_q != '0) : neg;
  assign term     = term_neg ? SW'(-SW'(term_mag)) : SW'(term_mag);

  // table writes and reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && 32'(entry_index_i) < 32'(MAX_CLUSTERS)) begin
      cx_mem[AW'(entry_index_i)] <= centre_x_i;
      cy_mem[AW'(entry_index_i)] <= centre_y_i;
      cw_mem[AW'(entry_index_i)] <= cluster_weight_in_i;
    end
    if (cmd_i.op == OP_RD) begin
      x_q <= cx_mem[idx_i];
      y_q <= cy_mem[idx_i];
      w_q <= cw_mem[idx_i];
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        time_q <= query_time_i;
        sum_q  <= '0;
        sat_q  <= 1'b0;
      end
      OP_SET_K:  k_q <= (period_i == 32'd0) ? '0 : div_quo[PB-1:0];
      OP_SET_A:  a_q <= 31'(p_q >> PB);
      OP_SET_U: begin
        u_q <= 32'(p_q >> 30);
        t_q <= 31'(ONE_Q30);
      end
      OP_SET_T:  t_q <= 31'(ONE_Q30 - 64'(t_quo));
      OP_SET_S: begin
        if (cmd_i.sel) begin
          ca_q <= (s64 > ONE_Q30) ? 31'(ONE_Q30) : s64[30:0];
        end else begin
          sa_q <= (s64 > ONE_Q30) ? 31'(ONE_Q30) : s64[30:0];
        end
      end
      OP_SET_CS: begin
        case (quad)
          2'd0:    begin cs_q <= 32'(ca_q);    sn_q <= 32'(sa_q);    end
          2'd1:    begin cs_q <= -32'(sa_q);   sn_q <= 32'(ca_q);    end
          2'd2:    begin cs_q <= -32'(ca_q);   sn_q <= -32'(sa_q);   end
          default: begin cs_q <= 32'(sa_q);    sn_q <= -32'(ca_q);   end
        endcase
      end
      OP_SET_DX, OP_SET_MX: acc_q <= 62'(p_q >> 2);
      OP_SET_DY: den_q <= 51'(sq_sum >> 12);
      OP_SET_M: begin
        omneg_q <= m2_big;
        om_q    <= 33'(om_diff >> 28);
      end
      OP_SET_W:  nw_q  <= 34'(p_q >> 30);
      OP_SET_N:  num_q <= p_q[63:0];
      OP_ADD_T: begin
        sum_q <= sum_q + term;
        sat_q <= sat_q | (den_q == '0) | term_big;
      end
      OP_OUT: begin
        if ($signed(sum_q) > $signed(SMAX)) begin
          out_data_q <= 32'h7fff_ffff;
          out_sat_q  <= 1'b1;
        end else if ($signed(sum_q) < $signed(SMIN)) begin
          out_data_q <= 32'h8000_0000;
          out_sat_q  <= 1'b1;
        end else begin
          out_data_q <= sum_q[31:0];
          out_sat_q  <= sat_q;
        end
      end
      default: ;
    endcase
    if (cmd_i.op == OP_MUL_A || cmd_i.op == OP_MUL_U || cmd_i.op == OP_MUL_UT ||
        cmd_i.op == OP_DIV_T || cmd_i.op == OP_MUL_S || cmd_i.op == OP_MUL_DX ||
        cmd_i.op == OP_MUL_DY || cmd_i.op == OP_MUL_MX || cmd_i.op == OP_MUL_MY ||
        cmd_i.op == OP_MUL_W || cmd_i.op == OP_MUL_N) begin
      p_q <= ma * mb;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign n_terms = (32'(clusters_i) > 32'(MAX_CLUSTERS)) ? NW'(MAX_CLUSTERS) : NW'(clusters_i);

  assign stat_o.div_busy  = div_busy;
  assign stat_o.den_zero  = den_q == '0;
  assign stat_o.out_busy  = out_valid_q & ~out_ready_i;
  assign stat_o.n_zero    = n_terms == '0;
  assign stat_o.last_term = (NW'(idx_i) + NW'(1)) == n_terms;

  assign out_valid_o = out_valid_q;
  assign density_o   = out_data_q;
  assign saturated_o = out_sat_q;

endmodule

FILE: src/ccde_ctrl.sv
`timescale 1ns / 1ps
module ccde_ctrl import ccde_pkg::*; #(
  parameter int AW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  output logic          in_ready_o,
  input  dp_stat_t      stat_i,
  output dp_cmd_t       cmd_o,
  output logic [AW-1:0] idx_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0,  ST_MOD   = 5'd1,  ST_KDIV  = 5'd2,
                         ST_SETK  = 5'd3,  ST_MULA  = 5'd4,  ST_SETA  = 5'd5,
                         ST_MULU  = 5'd6,  ST_SETU  = 5'd7,  ST_MULUT = 5'd8,
                         ST_DIVT  = 5'd9,  ST_SETT  = 5'd10, ST_MULS  = 5'd11,
                         ST_SETS  = 5'd12, ST_SETCS = 5'd13, ST_RD    = 5'd14,
                         ST_MDX   = 5'd15, ST_SDX   = 5'd16, ST_MDY   = 5'd17,
                         ST_SDY   = 5'd18, ST_MMX   = 5'd19, ST_SMX   = 5'd20,
                         ST_MMY   = 5'd21, ST_SMY   = 5'd22, ST_MW    = 5'd23,
                         ST_SW    = 5'd24, ST_MN    = 5'd25, ST_SN    = 5'd26,
                         ST_DIVQ  = 5'd27, ST_ADD   = 5'd28, ST_OUT   = 5'd29,
                         ST_DWAIT = 5'd30;

  logic [4:0]    state_q, state_d, ret_q, ret_d;
  logic [2:0]    m_q, m_d;
  logic          sel_q, sel_d;
  logic [AW-1:0] idx_q, idx_d;
  dp_op_e        op;

  // next state and command
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    m_d     = m_q;
    sel_d   = sel_q;
    idx_d   = idx_q;
    op      = OP_NOP;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i) begin
            op      = OP_LATCH;
            state_d = ST_MOD;
          end else begin
            op = OP_LOAD;
          end
        end
      end
      ST_MOD:  begin op = OP_DIV_MOD; ret_d = ST_KDIV; state_d = ST_DWAIT; end
      ST_KDIV: begin op = OP_DIV_K;   ret_d = ST_SETK; state_d = ST_DWAIT; end
      ST_SETK: begin op = OP_SET_K; sel_d = 1'b0; state_d = ST_MULA; end
      ST_MULA: begin op = OP_MUL_A; state_d = ST_SETA; end
      ST_SETA: begin op = OP_SET_A; state_d = ST_MULU; end
      ST_MULU: begin op = OP_MUL_U; state_d = ST_SETU; end
      ST_SETU: begin op = OP_SET_U; m_d = 3'd7; state_d = ST_MULUT; end
      ST_MULUT: begin op = OP_MUL_UT; state_d = ST_DIVT; end
      ST_DIVT: begin op = OP_DIV_T; state_d = ST_SETT; end
      ST_SETT: begin
        op = OP_SET_T;
        if (m_q == 3'd1) begin
          state_d = ST_MULS;
        end else begin
          m_d     = m_q - 3'd1;
          state_d = ST_MULUT;
        end
      end
      ST_MULS: begin op = OP_MUL_S; state_d = ST_SETS; end
      ST_SETS: begin
        op = OP_SET_S;
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = ST_MULA;
        end else begin
          state_d = ST_SETCS;
        end
      end
      ST_SETCS: begin
        op      = OP_SET_CS;
        idx_d   = '0;
        state_d = stat_i.n_zero ? ST_OUT : ST_RD;
      end
      ST_RD:  begin op = OP_RD;     state_d = ST_MDX; end
      ST_MDX: begin op = OP_MUL_DX; state_d = ST_SDX; end
      ST_SDX: begin op = OP_SET_DX; state_d = ST_MDY; end
      ST_MDY: begin op = OP_MUL_DY; state_d = ST_SDY; end
      ST_SDY: begin op = OP_SET_DY; state_d = ST_MMX; end
      ST_MMX: begin op = OP_MUL_MX; state_d = ST_SMX; end
      ST_SMX: begin op = OP_SET_MX; state_d = ST_MMY; end
      ST_MMY: begin op = OP_MUL_MY; state_d = ST_SMY; end
      ST_SMY: begin op = OP_SET_M;  state_d = ST_MW;  end
      ST_MW:  begin op = OP_MUL_W;  state_d = ST_SW;  end
      ST_SW:  begin op = OP_SET_W;  state_d = ST_MN;  end
      ST_MN:  begin op = OP_MUL_N;  state_d = ST_SN;  end
      ST_SN:  begin op = OP_SET_N;  state_d = ST_DIVQ; end
      ST_DIVQ: begin
        if (stat_i.den_zero) begin
          state_d = ST_ADD;
        end else begin
          op      = OP_DIV_Q;
          ret_d   = ST_ADD;
          state_d = ST_DWAIT;
        end
      end
      ST_ADD: begin
        op = OP_ADD_T;
        if (stat_i.last_term) begin
          state_d = ST_OUT;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_RD;
        end
      end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          op      = OP_OUT;
          state_d = ST_IDLE;
        end
      end
      ST_DWAIT: begin
        if (!stat_i.div_busy) begin
          state_d = ret_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      m_q     <= 3'd7;
      sel_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      m_q     <= m_d;
      sel_q   <= sel_d;
      idx_q   <= idx_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;
  assign cmd_o.op   = op;
  assign cmd_o.sel  = sel_q;
  assign cmd_o.m    = m_q;
  assign idx_o      = idx_q;

endmodule

FILE: src/circular_cluster_density_eval.sv
`timescale 1ns / 1ps
// load request: one per cycle while no query is in progress, no result
// query request: n entries are summed before the result; an entry whose denominator
// is zero skips the divider; one query at a time
// query time is set mostly by the shared 64-step restoring divider, one bit per cycle
// rst_ni clears control and the registers to 1 cluster and period 86400; tables stay unset
module circular_cluster_density_eval import ccde_pkg::*; #(
  parameter int MAX_CLUSTERS = 16,
  parameter int PHASE_BITS   = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index, centre_x, centre_y, cluster_weight_in, query_time, 4 zero bits
  input  logic [135:0] s_axis_tdata,
  // operation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // density
  output logic [31:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  logic [4:0]    clusters_q;
  logic [31:0]   period_q;
  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] idx;
  logic          cfg_wr;

  // configuration registers
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clusters_q <= CLUSTERS_RST;
      period_q   <= PERIOD_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CLUSTERS) begin
        clusters_q <= pwdata[4:0];
      end else begin
        period_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_PERIOD) ? period_q : 32'(clusters_q);
  assign pready = 1'b1;

  ccde_ctrl #(
    .AW (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  ccde_dp #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .PHASE_BITS   (PHASE_BITS),
    .AW           (AW)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .idx_i               (idx),
    .stat_o              (stat),
    .clusters_i          (clusters_q),
    .period_i            (period_q),
    .entry_index_i       (s_axis_tdata[3:0]),
    .centre_x_i          (s_axis_tdata[35:4]),
    .centre_y_i          (s_axis_tdata[67:36]),
    .cluster_weight_in_i (s_axis_tdata[99:68]),
    .query_time_i        (s_axis_tdata[131:100]),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .density_o           (m_axis_tdata),
    .saturated_o         (m_axis_tuser)
  );

endmodule

FILE: src/ccde_chk.sv
`timescale 1ns / 1ps
module ccde_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [135:0] s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [2:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a result never appears right after a request was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result too soon after request");

  // the cluster count register reads back only five bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && !paddr[2] |-> prdata[31:5] == 27'd0)
    else $error("cluster count read back too wide");

endmodule

bind circular_cluster_density_eval ccde_chk u_ccde_chk (.*);
